@@ rtl/core/pfba_pkg.sv @@
// ----------------------------------------------------------------------------
// Paged fixed block allocator package
// Shared command, result and state types for the allocator core.
// ----------------------------------------------------------------------------
package pfba_pkg;

	// Command codes carried by an input item.
	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_FREE    = 2'd1,
		OP_COMPACT = 2'd2,
		OP_REINIT  = 2'd3
	} opcode_t;

	// Status codes carried by a result item.
	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_NO_BLOCK = 2'd1,
		STS_NO_SLOT  = 2'd2,
		STS_BAD_FREE = 2'd3
	} status_t;

	// Register indexes on the configuration port.
	localparam logic REG_AUTO_EXTEND  = 1'b0;
	localparam logic REG_AUTO_COMPACT = 1'b1;

	typedef struct packed {
		opcode_t    opcode;
		logic [7:0] block_handle;
	} cmd_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] granted_handle;
		logic [4:0] pages_in_use;
		logic [8:0] blocks_allocated;
	} result_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_AL_CHK,
		S_AL_EV,
		S_FILL,
		S_FR_CHK,
		S_FR_EV,
		S_RL_RD,
		S_RL_EV,
		S_PL_WALK,
		S_CP_WALK,
		S_RI_WALK
	} fsm_t;

endpackage

@@ rtl/core/pfba_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pfba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Storage array with synchronous read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/paged_fixed_block_allocator_top.sv @@
// ----------------------------------------------------------------------------
// Paged fixed block allocator, top level
// Free-list block pool over page slots; the free links live in one RAM.
// ----------------------------------------------------------------------------
// Allocate steps through S_AL_CHK and S_AL_EV, or S_AL_CHK and S_FILL when a page is
// claimed. Free steps through S_FR_CHK and S_FR_EV; a page release then walks the free
// list (S_RL_RD, S_RL_EV) and the page list (S_PL_WALK). Compact and reset walk the page
// list, reset filling each page at one block per cycle. One item at a time.
// The result strobe is high for one cycle. Reset is asynchronous and leaves the
// pool empty with both auto bits set; no clearing pass is needed.
module paged_fixed_block_allocator_top #(
	parameter int PAGE_SLOTS      = 16,
	parameter int BLOCKS_PER_PAGE = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  pfba_pkg::cmd_t   cmd,
	output logic             busy,
	output logic             done,
	output pfba_pkg::result_t result,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	import pfba_pkg::*;

	localparam int TOTAL = PAGE_SLOTS * BLOCKS_PER_PAGE;
	localparam int BP    = $clog2(TOTAL + 1);
	localparam int BI    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int SW    = $clog2(PAGE_SLOTS + 1);
	localparam int SI    = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
	localparam int CW    = $clog2(BLOCKS_PER_PAGE + 1);
	localparam int FW    = (BLOCKS_PER_PAGE > 1) ? $clog2(BLOCKS_PER_PAGE) : 1;
	localparam logic [BP-1:0] NONE_B = BP'(TOTAL);
	localparam logic [SW-1:0] NONE_P = SW'(PAGE_SLOTS);
	localparam logic [FW-1:0] LAST_F = FW'(BLOCKS_PER_PAGE - 1);

	// Configuration registers.
	logic ext_q, cmp_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign prdata = {31'd0, (paddr[2] == REG_AUTO_COMPACT) ? cmp_q : ext_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_q <= 1'b1;
			cmp_q <= 1'b1;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_AUTO_EXTEND) begin
				ext_q <= pwdata[0];
			end else begin
				cmp_q <= pwdata[0];
			end
		end
	end

	// Sequencer and pool state.
	fsm_t            state_q, state_d;
	opcode_t         op_q;
	logic [7:0]      h_q;
	status_t         status_q, fin_status;
	logic [7:0]      grant_q;
	logic            done_q, fin, compact_q;
	logic [BP-1:0]   head_q, cur_q, prev_q;
	logic [SW-1:0]   phead_q, pcur_q, pprev_q, cp_q, pages_q;
	logic [SI-1:0]   slot_q;
	logic [FW-1:0]   fi_q;
	logic [BP-1:0]   blocks_q;
	logic            present_q [PAGE_SLOTS];
	logic [CW-1:0]   cnt_q     [PAGE_SLOTS];
	logic [SW-1:0]   plink_q   [PAGE_SLOTS];

	// RAM port.
	logic            ram_we, ram_re;
	logic [BI-1:0]   ram_waddr, ram_raddr;
	logic [BP:0]     ram_wdata, ram_rdata;
	logic [BP-1:0]   rd_link;
	logic            rd_inuse;

	pfba_ram #(.WIDTH(BP + 1), .DEPTH(TOTAL)) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_link  = ram_rdata[BP-1:0];
	assign rd_inuse = ram_rdata[BP];

	// Derived indexes.
	logic          h_ok, rel;
	logic [SI-1:0] h_slot, head_slot, cur_slot, pidx, cidx, fslot;
	logic          found;
	logic [BI-1:0] base;
	logic [BP-1:0] fill_link;

	assign h_ok      = 32'(h_q) < TOTAL;
	assign h_slot    = SI'(32'(h_q) / BLOCKS_PER_PAGE);
	assign head_slot = SI'(32'(head_q) / BLOCKS_PER_PAGE);
	assign cur_slot  = SI'(32'(cur_q) / BLOCKS_PER_PAGE);
	assign pidx      = SI'(pcur_q);
	assign cidx      = SI'(cp_q);
	assign base      = BI'(32'(slot_q) * BLOCKS_PER_PAGE);
	assign fill_link = (fi_q == '0) ? head_q
		: BP'(32'(slot_q) * BLOCKS_PER_PAGE + 32'(fi_q) - 1);
	assign rel       = cmp_q && (cnt_q[h_slot] <= CW'(1));

	// Lowest empty page slot.
	always_comb begin
		found = 1'b0;
		fslot = '0;
		for (int i = PAGE_SLOTS - 1; i >= 0; i--) begin
			if (!present_q[i]) begin
				found = 1'b1;
				fslot = SI'(i);
			end
		end
	end

	// Next state, RAM control and completion.
	always_comb begin
		state_d    = state_q;
		fin        = 1'b0;
		fin_status = STS_OK;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_waddr  = '0;
		ram_raddr  = '0;
		ram_wdata  = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (cmd.opcode)
						OP_ALLOC:   state_d = S_AL_CHK;
						OP_FREE:    state_d = S_FR_CHK;
						OP_COMPACT: state_d = S_CP_WALK;
						OP_REINIT:  state_d = S_RI_WALK;
					endcase
				end
			end
			S_AL_CHK: begin
				if (head_q != NONE_B) begin
					ram_re    = 1'b1;
					ram_raddr = BI'(head_q);
					state_d   = S_AL_EV;
				end else if (!ext_q) begin
					fin        = 1'b1;
					fin_status = STS_NO_BLOCK;
				end else if (!found) begin
					fin        = 1'b1;
					fin_status = STS_NO_SLOT;
				end else begin
					state_d = S_FILL;
				end
			end
			S_AL_EV: begin
				ram_we    = 1'b1;
				ram_waddr = BI'(head_q);
				ram_wdata = {1'b1, rd_link};
				fin       = 1'b1;
			end
			S_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = base + BI'(fi_q);
				ram_wdata = {(op_q == OP_ALLOC) && (fi_q == LAST_F), fill_link};
				if (fi_q == LAST_F) begin
					if (op_q == OP_ALLOC) begin
						fin = 1'b1;
					end else begin
						state_d = S_RI_WALK;
					end
				end
			end
			S_FR_CHK: begin
				if (!h_ok || !present_q[h_slot]) begin
					fin        = 1'b1;
					fin_status = STS_BAD_FREE;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = BI'(h_q);
					state_d   = S_FR_EV;
				end
			end
			S_FR_EV: begin
				if (!rd_inuse) begin
					fin        = 1'b1;
					fin_status = STS_BAD_FREE;
				end else begin
					ram_we    = 1'b1;
					ram_waddr = BI'(h_q);
					ram_wdata = {1'b0, head_q};
					if (rel) begin
						state_d = S_RL_RD;
					end else begin
						fin = 1'b1;
					end
				end
			end
			S_RL_RD: begin
				if (cur_q == NONE_B) begin
					state_d = S_PL_WALK;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = BI'(cur_q);
					state_d   = S_RL_EV;
				end
			end
			S_RL_EV: begin
				if (cur_slot == slot_q && prev_q != NONE_B) begin
					ram_we    = 1'b1;
					ram_waddr = BI'(prev_q);
					ram_wdata = {1'b0, rd_link};
				end
				state_d = S_RL_RD;
			end
			S_PL_WALK: begin
				if (pcur_q == NONE_P || pidx == slot_q) begin
					if (compact_q) begin
						state_d = S_CP_WALK;
					end else begin
						fin = 1'b1;
					end
				end
			end
			S_CP_WALK: begin
				if (cp_q == NONE_P) begin
					fin = 1'b1;
				end else if (cnt_q[cidx] == '0) begin
					state_d = S_RL_RD;
				end
			end
			S_RI_WALK: begin
				if (cp_q == NONE_P) begin
					fin = 1'b1;
				end else begin
					state_d = S_FILL;
				end
			end
			default: state_d = S_IDLE;
		endcase
		if (fin) begin
			state_d = S_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Pool state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q      <= OP_ALLOC;
			h_q       <= '0;
			status_q  <= STS_OK;
			grant_q   <= '0;
			done_q    <= 1'b0;
			compact_q <= 1'b0;
			head_q    <= NONE_B;
			cur_q     <= NONE_B;
			prev_q    <= NONE_B;
			phead_q   <= NONE_P;
			pcur_q    <= NONE_P;
			pprev_q   <= NONE_P;
			cp_q      <= NONE_P;
			pages_q   <= '0;
			blocks_q  <= '0;
			slot_q    <= '0;
			fi_q      <= '0;
			for (int i = 0; i < PAGE_SLOTS; i++) begin
				present_q[i] <= 1'b0;
				cnt_q[i]     <= '0;
				plink_q[i]   <= '0;
			end
		end else begin
			done_q <= fin;
			if (fin) begin
				status_q <= fin_status;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q      <= cmd.opcode;
						h_q       <= cmd.block_handle;
						grant_q   <= '0;
						cp_q      <= phead_q;
						compact_q <= (cmd.opcode == OP_COMPACT);
						if (cmd.opcode == OP_REINIT) begin
							head_q <= NONE_B;
						end
					end
				end
				S_AL_CHK: begin
					if (head_q == NONE_B && ext_q && found) begin
						present_q[fslot] <= 1'b1;
						plink_q[fslot]   <= phead_q;
						phead_q          <= SW'(fslot);
						pages_q          <= pages_q + SW'(1);
						cnt_q[fslot]     <= '0;
						slot_q           <= fslot;
						fi_q             <= '0;
					end
				end
				S_AL_EV: begin
					head_q             <= rd_link;
					cnt_q[head_slot]   <= cnt_q[head_slot] + CW'(1);
					blocks_q           <= blocks_q + BP'(1);
					grant_q            <= 8'(head_q);
				end
				S_FILL: begin
					fi_q <= fi_q + FW'(1);
					if (fi_q == LAST_F) begin
						if (op_q == OP_ALLOC) begin
							if (BLOCKS_PER_PAGE > 1) begin
								head_q <= BP'(32'(base) + BLOCKS_PER_PAGE - 2);
							end
							cnt_q[slot_q] <= CW'(1);
							blocks_q      <= blocks_q + BP'(1);
							grant_q       <= 8'(32'(base) + BLOCKS_PER_PAGE - 1);
						end else begin
							head_q <= BP'(32'(base) + BLOCKS_PER_PAGE - 1);
							cp_q   <= plink_q[slot_q];
						end
					end
				end
				S_FR_CHK: begin
				end
				S_FR_EV: begin
					if (rd_inuse) begin
						if (!rel) begin
							head_q <= BP'(h_q);
						end
						if (cnt_q[h_slot] != '0) begin
							cnt_q[h_slot] <= cnt_q[h_slot] - CW'(1);
							blocks_q      <= blocks_q - BP'(1);
						end
						slot_q <= h_slot;
						cur_q  <= head_q;
						prev_q <= NONE_B;
					end
				end
				S_RL_RD: begin
					if (cur_q == NONE_B) begin
						pcur_q  <= phead_q;
						pprev_q <= NONE_P;
					end
				end
				S_RL_EV: begin
					// Unlink entries of the page being released.
					if (cur_slot == slot_q) begin
						if (prev_q == NONE_B) begin
							head_q <= rd_link;
						end
					end else begin
						prev_q <= cur_q;
					end
					cur_q <= rd_link;
				end
				S_PL_WALK: begin
					if (pcur_q != NONE_P && pidx != slot_q) begin
						pprev_q <= pcur_q;
						pcur_q  <= plink_q[pidx];
					end else begin
						if (pcur_q != NONE_P) begin
							if (pprev_q == NONE_P) begin
								phead_q <= plink_q[pidx];
							end else begin
								plink_q[SI'(pprev_q)] <= plink_q[pidx];
							end
						end
						present_q[slot_q] <= 1'b0;
						cnt_q[slot_q]     <= '0;
						pages_q           <= pages_q - SW'(1);
					end
				end
				S_CP_WALK: begin
					if (cp_q != NONE_P) begin
						cp_q <= plink_q[cidx];
						if (cnt_q[cidx] == '0) begin
							slot_q <= cidx;
							cur_q  <= head_q;
							prev_q <= NONE_B;
						end
					end
				end
				S_RI_WALK: begin
					if (cp_q != NONE_P) begin
						slot_q      <= cidx;
						blocks_q    <= blocks_q - BP'(cnt_q[cidx]);
						cnt_q[cidx] <= '0;
						fi_q        <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Handshake and result.
	assign busy                    = (state_q != S_IDLE);
	assign done                    = done_q;
	assign result.status           = status_q;
	assign result.granted_handle   = grant_q;
	assign result.pages_in_use     = 5'(pages_q);
	assign result.blocks_allocated = 9'(blocks_q);

`ifndef SYNTH
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");
	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= NONE_B) else $error("free head out of range");
	a_pages_range: assert property (@(posedge clk) disable iff (!arst_n)
		pages_q <= SW'(PAGE_SLOTS)) else $error("page count out of range");
	a_page_list: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ((phead_q == NONE_P) == (pages_q == '0)))
		else $error("page list and page count disagree");
	a_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
`endif

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Paged fixed block allocator testbench
// Drives allocate, free, compact and reset items through the command port,
// sets the auto bits over the register port between phases, and checks each
// result against a model of the free list, page list and used counts.
// ----------------------------------------------------------------------------

import pfba_pkg::*;

// Tracks the pool state and holds the results that are still owed.
class pool_scoreboard;
	localparam int SLOTS = 16;
	localparam int BPP = 16;
	localparam int TOTAL = SLOTS * BPP;

	bit [8:0] free_next[TOTAL];
	bit [8:0] free_top;
	bit       slot_held[SLOTS];
	int       used_cnt[SLOTS];
	bit [4:0] page_next[SLOTS];
	bit [4:0] page_top;
	bit       block_taken[TOTAL];
	bit       extend_on;
	bit       compact_on;
	result_t  owed_q[$];
	int       mismatches;

	function new();
		free_top = 9'(TOTAL);
		page_top = 5'(SLOTS);
		extend_on = 1;
		compact_on = 1;
		mismatches = 0;
		for (int i = 0; i < TOTAL; i++) begin
			free_next[i] = 0;
			block_taken[i] = 0;
		end
		for (int s = 0; s < SLOTS; s++) begin
			slot_held[s] = 0;
			used_cnt[s] = 0;
			page_next[s] = 0;
		end
	endfunction

	// Pushes every block of a page, lowest first, so the highest is on top.
	function void push_page(int slot);
		int b;
		used_cnt[slot] = 0;
		for (int i = 0; i < BPP; i++) begin
			b = slot * BPP + i;
			block_taken[b] = 0;
			free_next[b] = free_top;
			free_top = 9'(b);
		end
	endfunction

	// Removes a page's blocks from the free list and unlinks the page.
	function void drop_page(int slot);
		int prev, cur, nxt, pprev, p;
		prev = TOTAL;
		cur = free_top;
		while (cur < TOTAL) begin
			nxt = free_next[cur];
			if (cur / BPP == slot) begin
				if (prev == TOTAL)
					free_top = 9'(nxt);
				else
					free_next[prev] = 9'(nxt);
			end else begin
				prev = cur;
			end
			cur = nxt;
		end
		pprev = SLOTS;
		p = page_top;
		while (p < SLOTS) begin
			if (p == slot) begin
				if (pprev == SLOTS)
					page_top = page_next[p];
				else
					page_next[pprev] = page_next[p];
				break;
			end
			pprev = p;
			p = page_next[p];
		end
		slot_held[slot] = 0;
		used_cnt[slot] = 0;
	endfunction

	function status_t grab_block(output bit [7:0] handle);
		int slot, b;
		handle = 0;
		if (free_top >= TOTAL) begin
			if (!extend_on)
				return STS_NO_BLOCK;
			for (slot = 0; slot < SLOTS; slot++)
				if (!slot_held[slot])
					break;
			if (slot >= SLOTS)
				return STS_NO_SLOT;
			slot_held[slot] = 1;
			page_next[slot] = page_top;
			page_top = 5'(slot);
			push_page(slot);
		end
		b = free_top;
		free_top = free_next[b];
		block_taken[b] = 1;
		used_cnt[b / BPP]++;
		handle = 8'(b);
		return STS_OK;
	endfunction

	function status_t give_back(int h);
		int slot;
		slot = h / BPP;
		if (!slot_held[slot] || !block_taken[h])
			return STS_BAD_FREE;
		block_taken[h] = 0;
		free_next[h] = free_top;
		free_top = 9'(h);
		if (used_cnt[slot] > 0)
			used_cnt[slot]--;
		if (compact_on && used_cnt[slot] == 0)
			drop_page(slot);
		return STS_OK;
	endfunction

	function void compact_pages();
		int p, nxt;
		p = page_top;
		while (p < SLOTS) begin
			nxt = page_next[p];
			if (used_cnt[p] == 0)
				drop_page(p);
			p = nxt;
		end
	endfunction

	function void refill_pages();
		int p;
		free_top = 9'(TOTAL);
		p = page_top;
		while (p < SLOTS) begin
			push_page(p);
			p = page_next[p];
		end
	endfunction

	// Applies an accepted item and queues the result it owes.
	function void note_cmd(cmd_t c);
		result_t r;
		bit [7:0] h;
		int pages, blocks;
		r = '0;
		h = 0;
		case (c.opcode)
			OP_ALLOC: r.status = grab_block(h);
			OP_FREE: r.status = give_back(c.block_handle);
			OP_COMPACT: begin
				compact_pages();
				r.status = STS_OK;
			end
			default: begin
				refill_pages();
				r.status = STS_OK;
			end
		endcase
		pages = 0;
		blocks = 0;
		for (int s = 0; s < SLOTS; s++) begin
			if (slot_held[s]) begin
				pages++;
				blocks += used_cnt[s];
			end
		end
		r.granted_handle = h;
		r.pages_in_use = 5'(pages);
		r.blocks_allocated = 9'(blocks);
		owed_q.push_back(r);
	endfunction

	function void check(result_t got);
		result_t want;
		if (owed_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Unexpected result: status %0d handle %0d pages %0d blocks %0d",
					got.status, got.granted_handle, got.pages_in_use,
					got.blocks_allocated);
			return;
		end
		want = owed_q.pop_front();
		if (got.status !== want.status || got.granted_handle !== want.granted_handle ||
				got.pages_in_use !== want.pages_in_use ||
				got.blocks_allocated !== want.blocks_allocated) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Mismatch: expected st %0d h %0d pg %0d blk %0d, got st %0d h %0d pg %0d blk %0d",
					want.status, want.granted_handle, want.pages_in_use,
					want.blocks_allocated, got.status, got.granted_handle,
					got.pages_in_use, got.blocks_allocated);
		end
	endfunction

	// Returns a block that is currently handed out, or any handle if none is.
	function bit [7:0] pick_taken();
		int taken_q[$];
		for (int i = 0; i < TOTAL; i++)
			if (block_taken[i])
				taken_q.push_back(i);
		if (taken_q.size() == 0)
			return 8'($urandom_range(255));
		return 8'(taken_q[$urandom_range(taken_q.size() - 1)]);
	endfunction
endclass

module tb;
	localparam int STALL_LIMIT = 60000;

	logic        clk;
	logic        arst_n;
	logic        start;
	cmd_t        cmd;
	logic        busy;
	logic        done;
	result_t     result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	pool_scoreboard sb;
	int  n_accepted;
	int  seen_accepted;
	int  quiet_cycles;
	bit  gaps_on;

	paged_fixed_block_allocator_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.cmd     (cmd),
		.busy    (busy),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Results are checked in order as the strobe marks them.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check(result);
	end

	// Ends the run if nothing moves for too long.
	always @(posedge clk) begin
		if (done || n_accepted != seen_accepted) begin
			quiet_cycles <= 0;
			seen_accepted <= n_accepted;
		end else if (arst_n) begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// Sends one item; start stays high until the item is taken.
	task automatic send_item(opcode_t op, bit [7:0] h);
		if (gaps_on && $urandom_range(3) == 0) begin
			@(negedge clk);
			start <= 0;
			repeat ($urandom_range(16, 1) - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1;
		cmd.opcode <= op;
		cmd.block_handle <= h;
		#1;
		while (busy) @(negedge clk);
		@(posedge clk);
		sb.note_cmd(cmd);
		n_accepted++;
	endtask

	task automatic drop_start();
		@(negedge clk);
		start <= 0;
	endtask

	// Lets the block drain before a register write.
	task automatic wait_idle();
		drop_start();
		while (sb.owed_q.size() != 0 || busy) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(bit [2:0] addr, bit [31:0] value);
		@(negedge clk);
		psel <= 1;
		pwrite <= 1;
		penable <= 0;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		if (addr == 3'(4 * REG_AUTO_EXTEND))
			sb.extend_on = value[0];
		else
			sb.compact_on = value[0];
	endtask

	task automatic set_mode(bit ext, bit cmp);
		wait_idle();
		write_reg(3'(4 * REG_AUTO_EXTEND), {$urandom_range(1) ? 31'h7fffffff : 31'd0, ext});
		write_reg(3'(4 * REG_AUTO_COMPACT), {31'd0, cmp});
	endtask

	// One random item, mostly allocate and well-formed frees.
	task automatic random_item(int alloc_pct);
		int r;
		r = $urandom_range(99);
		if (r < alloc_pct)
			send_item(OP_ALLOC, 8'($urandom_range(255)));
		else if (r < 92)
			send_item(OP_FREE, sb.pick_taken());
		else if (r < 96)
			send_item(OP_FREE, 8'($urandom_range(255)));
		else if (r < 98)
			send_item(OP_COMPACT, 8'($urandom_range(255)));
		else
			send_item(OP_REINIT, 8'($urandom_range(255)));
	endtask

	initial begin
		sb = new();
		n_accepted = 0;
		seen_accepted = 0;
		quiet_cycles = 0;
		gaps_on = 1;
		arst_n = 0;
		start = 0;
		cmd = '0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: claim, frees good and bad, compact and reset.
		send_item(OP_ALLOC, 8'hff);
		send_item(OP_ALLOC, 8'h00);
		send_item(OP_ALLOC, 8'h00);
		send_item(OP_FREE, 8'd14);
		send_item(OP_FREE, 8'd14);
		send_item(OP_FREE, 8'd255);
		send_item(OP_FREE, 8'd0);
		send_item(OP_ALLOC, 8'h00);
		send_item(OP_COMPACT, 8'h00);
		send_item(OP_REINIT, 8'h00);
		send_item(OP_ALLOC, 8'h00);
		send_item(OP_FREE, 8'd15);
		send_item(OP_FREE, 8'd14);
		send_item(OP_FREE, 8'd13);

		// Empty pool with extend off.
		set_mode(0, 1);
		send_item(OP_ALLOC, 8'h00);
		send_item(OP_FREE, 8'd0);
		send_item(OP_COMPACT, 8'h00);

		// Pages kept at zero count, then compacted.
		set_mode(1, 0);
		send_item(OP_ALLOC, 8'h00);
		send_item(OP_FREE, 8'd15);
		send_item(OP_COMPACT, 8'h00);
		send_item(OP_REINIT, 8'h00);

		// Fill the pool with mostly allocate items.
		for (int i = 0; i < 300; i++)
			random_item(88);

		set_mode(0, 1);
		for (int i = 0; i < 60; i++)
			random_item(40);

		set_mode(1, 1);
		for (int i = 0; i < 30; i++)
			random_item(55);
		gaps_on = 0;
		for (int i = 0; i < 40; i++)
			random_item(55);
		drop_start();

		while (sb.owed_q.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		if (sb.mismatches == 0 && sb.owed_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
